@@ rtl/tahm_pkg.sv @@
// Package for the time-by-address heat map binner: grid sizes, widths, register codes.
// No dependencies.
`timescale 1ns / 1ps
package tahm_pkg;
	localparam int TIME_BINS = 64;
	localparam int MEM_BINS  = 1024;
	localparam int MAX_RUN   = 64;
	localparam int TB_W      = $clog2(TIME_BINS);
	localparam int MB_W      = $clog2(MEM_BINS);
	localparam int CELL_W    = TB_W + MB_W;
	localparam int CELLS     = TIME_BINS * MEM_BINS;
	localparam int RUN_W     = $clog2(MAX_RUN + 1);
	localparam int PADDR_W   = 3;
	localparam logic [PADDR_W-1:0] REG_TSLICE    = 3'd0;
	localparam logic [PADDR_W-1:0] REG_MEM_SLICE = 3'd4;
	localparam logic [1:0] DIV_TIME = 2'd0;
	localparam logic [1:0] DIV_LO   = 2'd1;
	localparam logic [1:0] DIV_HI   = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic       load;     // capture input beat
		logic       set_start;
		logic       div_go;
		logic [1:0] div_sel;
		logic       run_init;
		logic       rd;       // counter read
		logic       wr;       // counter write + emit result
		logic       clr;      // clearing sweep write
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_start;
		logic div_done;
		logic empty;
		logic run_last;
		logic clr_last;
	} sts_t;
endpackage

@@ rtl/tahm_if.sv @@
// Valid/ready stream interfaces for input events and result beats.
// Depends on nothing.
`timescale 1ns / 1ps
interface tahm_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [47:0] time_us;
	logic [31:0] blk_base;
	logic [31:0] block_size;
	modport source (output valid, mode, time_us, blk_base, block_size, input ready);
	modport sink (input valid, mode, time_us, blk_base, block_size, output ready);
endinterface

interface tahm_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  time_bin;
	logic [9:0]  memory_bin;
	logic [31:0] quantity;
	logic        out_of_range;
	logic        last;
	modport source (output valid, time_bin, memory_bin, quantity, out_of_range, last,
		input ready);
	modport sink (input valid, time_bin, memory_bin, quantity, out_of_range, last,
		output ready);
endinterface

@@ rtl/time_address_heat_map_binner.sv @@
// Time-by-address heat map binner top level: APB registers, controller, datapath.
// Uses tahm_pkg, tahm_if, tahm_ctrl, tahm_datapath.
// An entry event runs three serial divisions (time bin, first and end memory bin), then
// a counter read and an emit per result beat; a start event only sets the time origin.
// After reset a clearing sweep over all 65536 cells zeroes the counter memory; no input is taken.
`timescale 1ns / 1ps
module time_address_heat_map_binner
	import tahm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	tahm_in_if.sink            in_if,
	tahm_out_if.source         out_if
);
	logic [31:0] ts_q, ms_q;
	ctl_t ctl;
	sts_t sts;

	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= 32'd1;
			ms_q <= 32'd4096;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				REG_TSLICE:    ts_q <= pwdata;
				REG_MEM_SLICE: ms_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_TSLICE:    prdata = ts_q;
			REG_MEM_SLICE: prdata = ms_q;
			default:       prdata = 32'd0;
		endcase
	end

	tahm_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(in_if.valid),
		.in_ready(in_if.ready), .out_valid(out_if.valid), .out_ready(out_if.ready),
		.sts(sts), .ctl(ctl));

	tahm_datapath u_dp (.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.tslice_us(ts_q), .mem_slice(ms_q), .in_mode(in_if.mode), .in_time(in_if.time_us),
		.in_bstart(in_if.blk_base), .in_bsize(in_if.block_size),
		.o_tbin(out_if.time_bin), .o_mbin(out_if.memory_bin), .o_qty(out_if.quantity),
		.o_oor(out_if.out_of_range), .o_last(out_if.last));
endmodule

@@ rtl/tahm_div.sv @@
// Restoring divider, one quotient bit per cycle, 49-bit dividend by 32-bit divisor.
// Uses tahm_pkg.
`timescale 1ns / 1ps
module tahm_div
	import tahm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [48:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [48:0] quot
);
	logic [48:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] sh;
	logic [33:0] diff;

	assign sh   = {r_q, q_q[48]};
	assign diff = sh - {2'b0, d_q};

	// busy flag and step counter for the shift-subtract steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd49;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= (divisor == 32'd0) ? 32'd1 : divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				r_q <= diff[32:0];
				q_q <= {q_q[47:0], 1'b1};
			end else begin
				r_q <= sh[32:0];
				q_q <= {q_q[47:0], 1'b0};
			end
		end
	end

	assign done = busy_q && cnt_q == 6'd1;
	assign quot = {q_q[47:0], ~diff[33]};
endmodule

@@ rtl/tahm_datapath.sv @@
// Datapath: event registers, shared divider, bin run counter, counter memory, output beat.
// Uses tahm_pkg, tahm_div.
`timescale 1ns / 1ps
module tahm_datapath
	import tahm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [31:0] tslice_us,
	input  logic [31:0] mem_slice,
	input  logic        in_mode,
	input  logic [47:0] in_time,
	input  logic [31:0] in_bstart,
	input  logic [31:0] in_bsize,
	output logic [5:0]  o_tbin,
	output logic [9:0]  o_mbin,
	output logic [31:0] o_qty,
	output logic        o_oor,
	output logic        o_last
);
	logic [47:0] start_q, time_q;
	logic [31:0] bstart_q, bsize_q;
	logic        mode_q;
	logic [48:0] tbin_q, lo_q, hi_q, mbin_q;
	logic [RUN_W-1:0] left_q;
	logic        trunc_q;
	logic [CELL_W-1:0] clr_q;
	logic [31:0] mem [CELLS];
	logic [31:0] rd_q;
	logic        div_done;
	logic [48:0] quot, dividend, count;
	logic [31:0] divisor, ms_nz;
	logic        on_grid;
	logic [CELL_W-1:0] addr;

	assign ms_nz = (mem_slice == 32'd0) ? 32'd1 : mem_slice;

	// divider operand select
	always_comb begin
		case (ctl.div_sel)
			DIV_TIME: begin
				dividend = {1'b0, time_q - start_q};
				divisor  = tslice_us;
			end
			DIV_LO: begin
				dividend = {17'd0, bstart_q};
				divisor  = mem_slice;
			end
			DIV_HI: begin
				dividend = {17'd0, bstart_q} + {17'd0, bsize_q} + {17'd0, ms_nz} - 49'd1;
				divisor  = mem_slice;
			end
			default: begin
				dividend = '0;
				divisor  = 32'd1;
			end
		endcase
	end

	tahm_div u_div (.clk(clk), .arst_n(arst_n), .go(ctl.div_go), .dividend(dividend),
		.divisor(divisor), .done(div_done), .quot(quot));

	assign count = hi_q - lo_q;

	// event capture, quotients, run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			clr_q   <= '0;
		end else begin
			if (ctl.set_start) start_q <= time_q;
			if (ctl.clr) clr_q <= clr_q + CELL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q   <= in_mode;
			time_q   <= in_time;
			bstart_q <= in_bstart;
			bsize_q  <= in_bsize;
		end
		if (div_done) begin
			case (ctl.div_sel)
				DIV_TIME: tbin_q <= quot;
				DIV_LO:   lo_q   <= quot;
				default:  hi_q   <= quot;
			endcase
		end
		if (ctl.run_init) begin
			mbin_q  <= lo_q;
			trunc_q <= count > 49'(MAX_RUN);
			left_q  <= (count > 49'(MAX_RUN)) ? RUN_W'(MAX_RUN) : count[RUN_W-1:0];
		end else if (ctl.wr) begin
			mbin_q <= mbin_q + 49'd1;
			left_q <= left_q - RUN_W'(1);
		end
	end

	assign on_grid = tbin_q < 49'(TIME_BINS) && mbin_q < 49'(MEM_BINS);
	assign addr = ctl.clr ? clr_q : {tbin_q[TB_W-1:0], mbin_q[MB_W-1:0]};

	// counter memory
	always_ff @(posedge clk) begin
		if (ctl.clr)
			mem[addr] <= '0;
		else if (ctl.wr && on_grid && rd_q != 32'hFFFF_FFFF)
			mem[addr] <= rd_q + 32'd1;
		if (ctl.rd) rd_q <= mem[addr];
	end

	// result fields for the emit cycle
	always_comb begin
		o_tbin = tbin_q[5:0];
		o_mbin = mbin_q[9:0];
		o_qty  = on_grid ? ((rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1) : 32'd0;
		o_last = left_q == RUN_W'(1);
		o_oor  = !on_grid || (o_last && trunc_q);
	end

	assign sts.is_start = !mode_q;
	assign sts.div_done = div_done;
	assign sts.empty    = hi_q <= lo_q;
	assign sts.run_last = left_q == RUN_W'(1);
	assign sts.clr_last = &clr_q;
endmodule

@@ rtl/tahm_ctrl.sv @@
// Controller state machine: clear sweep, accept, three divisions, read/emit per bin.
// Uses tahm_pkg.
`timescale 1ns / 1ps
module tahm_ctrl
	import tahm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output ctl_t ctl
);
	localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_DEC = 3'd2, S_DIV = 3'd3,
		S_INIT = 3'd4, S_RD = 3'd5, S_EMIT = 3'd6;
	logic [2:0] st_q;
	logic [1:0] sel_q;
	logic       go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLR;
			sel_q <= DIV_TIME;
			go_q  <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (st_q)
				S_CLR: if (sts.clr_last) st_q <= S_IDLE;
				S_IDLE: if (in_valid) st_q <= S_DEC;
				S_DEC: begin
					if (sts.is_start) st_q <= S_IDLE;
					else begin
						st_q <= S_DIV; sel_q <= DIV_TIME; go_q <= 1'b1;
					end
				end
				S_DIV: if (sts.div_done) begin
					if (sel_q == DIV_HI) st_q <= S_INIT;
					else begin
						sel_q <= sel_q + 2'd1; go_q <= 1'b1;
					end
				end
				S_INIT: st_q <= sts.empty ? S_IDLE : S_RD;
				S_RD: st_q <= S_EMIT;
				S_EMIT: if (out_ready) st_q <= sts.run_last ? S_IDLE : S_RD;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready      = st_q == S_IDLE;
		out_valid     = st_q == S_EMIT;
		ctl.load      = in_ready && in_valid;
		ctl.set_start = st_q == S_DEC && sts.is_start;
		ctl.div_go    = go_q;
		ctl.div_sel   = sel_q;
		ctl.run_init  = st_q == S_INIT && !sts.empty;
		ctl.rd        = st_q == S_RD;
		ctl.wr        = out_valid && out_ready;
		ctl.clr       = st_q == S_CLR;
	end

	a_emit_rd: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_EMIT |-> $past(st_q) == S_RD || $past(st_q) == S_EMIT)
		else $error("emit without read");
	a_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept during emit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("beat dropped");
endmodule

@@ sim/time_address_heat_map_binner_tb.sv @@
// Self-checking testbench for the time-by-address heat map binner.
// Depends on tahm_pkg, tahm_if and the block's top level.
`timescale 1ns / 1ps
module time_address_heat_map_binner_tb;
	import tahm_pkg::*;

	typedef struct packed {
		logic [5:0]  time_bin;
		logic [9:0]  memory_bin;
		logic [31:0] quantity;
		logic        out_of_range;
		logic        last;
	} heat_beat_t;

	// Heat map predictor and queue of expected beats
	class heat_map_board;
		logic [31:0] slice_us;
		logic [31:0] slice_bytes;
		logic [47:0] origin;
		logic [31:0] counts [int];
		heat_beat_t  pending [$];
		int          mismatches;
		int          beats_seen;
		int          flagged;

		function void reset_state();
			slice_us = 1;
			slice_bytes = 4096;
			origin = 0;
			counts.delete();
			pending.delete();
		endfunction

		function void note_event(logic mode, logic [47:0] t, logic [31:0] bs, logic [31:0] sz);
			logic [63:0] ts, ms, rel, tbin, first, endb, n, mbin;
			logic        cut;
			heat_beat_t  b;
			int          key;
			if (mode == 1'b0) begin
				origin = t;
				return;
			end
			ts = (slice_us == 0) ? 64'd1 : {32'd0, slice_us};
			ms = (slice_bytes == 0) ? 64'd1 : {32'd0, slice_bytes};
			rel = {16'd0, t - origin};
			tbin = rel / ts;
			first = {32'd0, bs} / ms;
			endb = ({32'd0, bs} + {32'd0, sz} + ms - 1) / ms;
			if (endb <= first)
				return;
			n = endb - first;
			cut = n > MAX_RUN;
			if (cut)
				n = MAX_RUN;
			for (int i = 0; i < n; i++) begin
				mbin = first + i;
				b.time_bin = tbin[5:0];
				b.memory_bin = mbin[9:0];
				b.quantity = 0;
				b.out_of_range = 1'b0;
				if (tbin < TIME_BINS && mbin < MEM_BINS) begin
					key = int'(tbin) * MEM_BINS + int'(mbin);
					if (!counts.exists(key))
						counts[key] = 0;
					if (counts[key] != 32'hFFFF_FFFF)
						counts[key]++;
					b.quantity = counts[key];
				end else begin
					b.out_of_range = 1'b1;
				end
				if (i == n - 1 && cut)
					b.out_of_range = 1'b1;
				b.last = (i == n - 1);
				pending.push_back(b);
			end
		endfunction

		function void check_beat(heat_beat_t got);
			heat_beat_t want;
			beats_seen++;
			if (got.out_of_range)
				flagged++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("beat mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	tahm_in_if  in_if ();
	tahm_out_if out_if ();

	time_address_heat_map_binner dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_if(in_if.sink), .out_if(out_if.source)
	);

	heat_map_board board;
	int  idle_pct;       // idling percentage for both sides, 0 during quiet stretch
	bit  hold_sink;      // long receiver hold-off
	int  events_sent;
	int  quiet_cycles;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Result side: random ready, checks each beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready)
				board.check_beat({out_if.time_bin, out_if.memory_bin, out_if.quantity,
					out_if.out_of_range, out_if.last});
			out_if.ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
		end
	end

	// Watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 200000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_TSLICE)
			board.slice_us = data;
		else if (addr == REG_MEM_SLICE)
			board.slice_bytes = data;
	endtask

	// Offer one event, random idle first; valid stays high across back-to-back beats
	task automatic send_event(logic mode, logic [47:0] t, logic [31:0] bs, logic [31:0] sz);
		while ($urandom_range(99) < idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.mode <= mode;
		in_if.time_us <= t;
		in_if.blk_base <= bs;
		in_if.block_size <= sz;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		board.note_event(mode, t, bs, sz);
		events_sent++;
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (400)
			@(posedge clk);
	endtask

	// Random entry: mostly small blocks near the start, a few long, far or empty ones
	task automatic random_entry(logic [47:0] base);
		logic [31:0] bs, sz;
		logic [47:0] t;
		int          pick;
		pick = $urandom_range(99);
		t = base + $urandom_range(4000);
		bs = $urandom_range(board.slice_bytes < 40 ? 2000 : 600000);
		sz = $urandom_range(board.slice_bytes < 40 ? 100 : 20000);
		if (pick < 6) begin
			bs = $urandom;
			sz = $urandom;
		end else if (pick < 10) begin
			t = 48'({$urandom, $urandom});
		end else if (pick < 14) begin
			sz = 0;
		end
		send_event(1'b1, t, bs, sz);
	endtask

	initial begin
		logic [47:0] base;
		board = new();
		board.reset_state();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_if.valid = 1'b0;
		in_if.mode = 1'b0;
		in_if.time_us = '0;
		in_if.blk_base = '0;
		in_if.block_size = '0;
		idle_pct = 0;
		hold_sink = 0;
		events_sent = 0;
		quiet_cycles = 0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset widths, entry before any start, extremes
		send_event(1'b1, 48'd5, 32'd0, 32'd1);
		send_event(1'b1, 48'd5, 32'd0, 32'd1);
		send_event(1'b1, 48'd63, 32'd4096 * 1023, 32'd4096);
		send_event(1'b1, 48'd64, 32'd0, 32'd10);
		send_event(1'b1, 48'd3, 32'd4096 * 1024, 32'd1);
		send_event(1'b0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(1'b1, 48'd0, 32'd100, 32'd0);
		send_event(1'b1, 48'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(1'b0, 48'd1000, 32'd0, 32'd0);
		send_event(1'b1, 48'd999, 32'd0, 32'd4096);
		send_event(1'b1, 48'd1001, 32'd0, 32'd4096 * 70);
		send_event(1'b1, 48'd1002, 32'd4095, 32'd2);
		drain();

		// Zero widths act as one
		reg_write(REG_TSLICE, 32'd0);
		reg_write(REG_MEM_SLICE, 32'd0);
		send_event(1'b1, 48'd1030, 32'd1000, 32'd5);
		send_event(1'b1, 48'd1030, 32'd1000, 32'd100);
		drain();

		// Maximum widths: extreme operands, one event off the time grid, one in bin 0
		reg_write(REG_TSLICE, 32'hFFFF_FFFF);
		reg_write(REG_MEM_SLICE, 32'hFFFF_FFFF);
		send_event(1'b1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(1'b1, 48'd2000, 32'hFFFF_FFFE, 32'd1);
		drain();

		// Random phases over several width settings
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					reg_write(REG_TSLICE, 32'd100);
					reg_write(REG_MEM_SLICE, 32'd4096);
				end
				1: begin
					reg_write(REG_TSLICE, 32'd1);
					reg_write(REG_MEM_SLICE, 32'd16);
				end
				2: begin
					reg_write(REG_TSLICE, $urandom_range(200, 1));
					reg_write(REG_MEM_SLICE, $urandom_range(65536, 512));
				end
				default: begin
					reg_write(REG_TSLICE, 32'd70);
					reg_write(REG_MEM_SLICE, 32'd1024);
				end
			endcase
			base = 48'({$urandom, $urandom});
			send_event(1'b0, base, $urandom, $urandom);
			for (int k = 0; k < 110; k++) begin
				idle_pct = (phase == 1 && k < 40) ? 0 : 32;
				if (phase == 2 && k == 20) begin
					// receiver holds off while events keep coming
					fork
						begin
							hold_sink = 1;
							repeat (600)
								@(posedge clk);
							hold_sink = 0;
						end
					join_none
				end
				if ($urandom_range(99) < 4)
					send_event(1'b0, base + $urandom_range(50), $urandom, $urandom);
				else
					random_entry(base);
			end
			drain();
		end

		$display("Sent %0d events, checked %0d result beats (%0d flagged out of range).",
			events_sent, board.beats_seen, board.flagged);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
